@@ design/tlb_shootdown_tracker_core_defines.svh @@
`ifndef TLB_SHOOTDOWN_TRACKER_CORE_DEFINES_SVH
`define TLB_SHOOTDOWN_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsd check failed");

// next-cycle implication, checked out of reset
`define TSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsd check failed");

`endif

@@ design/tsd_pkg.sv @@
`default_nettype none
package tsd_pkg;

    localparam int MAX_CPUS  = 8;
    localparam int ASID_BITS = 16;
    localparam int IDX_W     = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CNT_W     = 6;

    localparam logic [15:0] ASID_MASK =
        (ASID_BITS >= 16) ? 16'hFFFF : 16'((1 << ASID_BITS) - 1);

    localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(8);

    typedef enum logic {
        OP_TRIGGER = 1'b0,
        OP_SERVICE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        KIND_INVAL  = 3'd0,
        KIND_DONE   = 3'd1,
        KIND_BUSY   = 3'd2,
        KIND_NONE   = 3'd3,
        KIND_BADCPU = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SDONE,
        ST_TDONE,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [4:0]  cpu_id;
        logic [15:0] asid;
        logic [63:0] addr;
        logic [31:0] length;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  target_cpu;
        logic [4:0]  initiator;
        logic [15:0] inv_asid;
        logic [63:0] inv_addr;
        logic [31:0] inv_length;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] asid;
        logic [63:0] addr;
        logic [31:0] length;
    } t_rec;

    typedef struct packed {
        logic                inval;
        logic                done;
        logic [MAX_CPUS-1:0] map_new;
        logic [CNT_W-1:0]    cnt_new;
    } t_ack;

endpackage
`default_nettype wire

@@ design/tsd_rec_ram.sv @@
`default_nettype none
module tsd_rec_ram (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [tsd_pkg::IDX_W-1:0] i_waddr,
    input  wire tsd_pkg::t_rec             i_wdata,
    input  wire logic [tsd_pkg::IDX_W-1:0] i_raddr,
    output tsd_pkg::t_rec                  o_rdata
);
    import tsd_pkg::*;

    t_rec r_mem [MAX_CPUS];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ design/tsd_ack_unit.sv @@
`default_nettype none
module tsd_ack_unit (
    input  wire logic                         i_pending,
    input  wire logic [tsd_pkg::MAX_CPUS-1:0] i_map,
    input  wire logic [tsd_pkg::CNT_W-1:0]    i_count,
    input  wire logic [tsd_pkg::IDX_W-1:0]    i_cpu,
    input  wire logic [tsd_pkg::CNT_W-1:0]    i_need,
    output tsd_pkg::t_ack                     o_ack
);
    import tsd_pkg::*;

    logic [MAX_CPUS-1:0] cpu_bit;

    always_comb begin
        cpu_bit       = MAX_CPUS'(1) << i_cpu;
        o_ack.inval   = i_pending && !i_map[i_cpu];
        o_ack.map_new = o_ack.inval ? (i_map | cpu_bit) : i_map;
        o_ack.cnt_new = i_count + CNT_W'(o_ack.inval);
        // a lowered cpu count can complete a record already acknowledged
        o_ack.done    = i_pending && (o_ack.cnt_new >= i_need);
    end

endmodule
`default_nettype wire

@@ design/tlb_shootdown_tracker_core.sv @@
`default_nettype none
// bad cpu or busy trigger: one result, strobed the cycle after the accept, busy stays low
// trigger: invalidate staged then registered, busy in FIN; one cpu: completion next, TDONE too
// service: busy in SCAN for every record (MAX_CPUS), in SDONE for each one acked and completed
//   in the same visit and in FIN to release the staged result; last result strobed as busy falls
// one result per cycle at most, receiver cannot stall; one held back so the last is marked
// reset clears records' pending, ack map and count and sets cpus in use to 8; range data unreset
module tlb_shootdown_tracker_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire tsd_pkg::t_in_item          i_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [tsd_pkg::CNT_W-1:0]  i_cfg_data,
    output logic                            o_strobe,
    output tsd_pkg::t_out_item              o_result
);
    import tsd_pkg::*;

    `include "tlb_shootdown_tracker_core_defines.svh"

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [4:0]          r_cpu;
    logic [CNT_W-1:0]    r_cfg;
    logic [MAX_CPUS-1:0] r_pending;
    logic [MAX_CPUS-1:0] r_map   [MAX_CPUS];
    logic [CNT_W-1:0]    r_count [MAX_CPUS];
    t_out_item           r_stage, n_stage;
    logic                r_stage_v, n_stage_v;
    t_out_item           r_res, n_res;
    logic                r_stb, n_stb;

    logic [CNT_W-1:0]    eff_n;
    logic                accept;
    logic [IDX_W-1:0]    in_idx;
    logic                push;
    t_out_item           push_item;
    logic                trig_wr;
    logic                scan_upd;
    logic                clr_pend;
    t_rec                wr_rec;
    t_rec                rd_rec;
    t_ack                ack;

    tsd_rec_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (trig_wr),
        .i_waddr (in_idx),
        .i_wdata (wr_rec),
        .i_raddr (n_idx),
        .o_rdata (rd_rec)
    );

    tsd_ack_unit u_ack (
        .i_pending (r_pending[r_idx]),
        .i_map     (r_map[r_idx]),
        .i_count   (r_count[r_idx]),
        .i_cpu     (r_cpu[IDX_W-1:0]),
        .i_need    (eff_n),
        .o_ack     (ack)
    );

    always_comb begin
        if (r_cfg == '0) begin
            eff_n = CNT_W'(1);
        end else if (r_cfg > CNT_W'(MAX_CPUS)) begin
            eff_n = CNT_W'(MAX_CPUS);
        end else begin
            eff_n = r_cfg;
        end
    end

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign in_idx = i_item.cpu_id[IDX_W-1:0];

    always_comb begin
        wr_rec.asid   = i_item.asid & ASID_MASK;
        wr_rec.addr   = i_item.addr;
        wr_rec.length = i_item.length;
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_stage   = r_stage;
        n_stage_v = r_stage_v;
        n_res     = r_res;
        n_stb     = 1'b0;
        push      = 1'b0;
        push_item = r_stage;
        trig_wr   = 1'b0;
        scan_upd  = 1'b0;
        clr_pend  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    if (CNT_W'(i_item.cpu_id) >= eff_n) begin
                        n_res = '{kind: KIND_BADCPU, target_cpu: '0,
                                  initiator: i_item.cpu_id, inv_asid: '0,
                                  inv_addr: '0, inv_length: '0, last: 1'b1};
                        n_stb = 1'b1;
                    end else if (i_item.operation == OP_SERVICE) begin
                        n_state = ST_SCAN;
                    end else if (r_pending[in_idx]) begin
                        n_res = '{kind: KIND_BUSY, target_cpu: '0,
                                  initiator: i_item.cpu_id, inv_asid: '0,
                                  inv_addr: '0, inv_length: '0, last: 1'b1};
                        n_stb = 1'b1;
                    end else begin
                        trig_wr   = 1'b1;
                        push      = 1'b1;
                        push_item = '{kind: KIND_INVAL, target_cpu: i_item.cpu_id,
                                      initiator: i_item.cpu_id, inv_asid: wr_rec.asid,
                                      inv_addr: wr_rec.addr, inv_length: wr_rec.length,
                                      last: 1'b0};
                        n_state   = (eff_n == CNT_W'(1)) ? ST_TDONE : ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                scan_upd = ack.inval;
                clr_pend = ack.done;
                if (ack.inval || ack.done) begin
                    push      = 1'b1;
                    push_item = '{kind: ack.inval ? KIND_INVAL : KIND_DONE,
                                  target_cpu: ack.inval ? r_cpu : 5'd0,
                                  initiator: 5'(r_idx), inv_asid: rd_rec.asid,
                                  inv_addr: rd_rec.addr, inv_length: rd_rec.length,
                                  last: 1'b0};
                end
                if (ack.inval && ack.done) begin
                    n_state = ST_SDONE;
                end else if (r_idx == IDX_W'(MAX_CPUS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_SDONE, ST_TDONE: begin
                // completion carries the range of the invalidate just staged
                push                 = 1'b1;
                push_item.kind       = KIND_DONE;
                push_item.target_cpu = '0;
                if (r_state == ST_TDONE || r_idx == IDX_W'(MAX_CPUS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_SCAN;
                    n_idx   = r_idx + IDX_W'(1);
                end
            end
            ST_FIN: begin
                if (r_stage_v) begin
                    n_res      = r_stage;
                    n_res.last = 1'b1;
                end else begin
                    n_res = '{kind: KIND_NONE, target_cpu: '0, initiator: r_cpu,
                              inv_asid: '0, inv_addr: '0, inv_length: '0, last: 1'b1};
                end
                n_stb     = 1'b1;
                n_stage_v = 1'b0;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hold one result back so the final one can be marked
        if (push) begin
            n_stb     = r_stage_v;
            n_res     = r_stage;
            n_stage   = push_item;
            n_stage_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_cfg     <= CFG_RESET;
            r_stage_v <= 1'b0;
            r_stb     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_stage_v <= n_stage_v;
            r_stb     <= n_stb;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
        r_res   <= n_res;
        if (accept) begin
            r_cpu <= i_item.cpu_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            for (int i = 0; i < MAX_CPUS; i++) begin
                r_map[i]   <= '0;
                r_count[i] <= '0;
            end
        end else if (trig_wr) begin
            r_pending[in_idx] <= (eff_n != CNT_W'(1));
            r_map[in_idx]     <= MAX_CPUS'(1) << in_idx;
            r_count[in_idx]   <= CNT_W'(1);
        end else begin
            if (scan_upd) begin
                r_map[r_idx]   <= ack.map_new;
                r_count[r_idx] <= ack.cnt_new;
            end
            if (clr_pend) begin
                r_pending[r_idx] <= 1'b0;
            end
        end
    end

    assign o_strobe = r_stb;
    assign o_result = r_res;

    `TSD_ASSERT_NOW(a_last_idle, o_strobe && o_result.last, !busy)
    `TSD_ASSERT_NOW(a_sdone_staged, r_state == ST_SDONE || r_state == ST_TDONE,
        r_stage_v && r_stage.kind == KIND_INVAL)
    `TSD_ASSERT_NEXT(a_badcpu, accept && (CNT_W'(i_item.cpu_id) >= eff_n),
        o_strobe && o_result.kind == KIND_BADCPU && !busy)
    `TSD_ASSERT_NEXT(a_fin_idle, r_state == ST_FIN, o_strobe && o_result.last && !r_stage_v)

endmodule
`default_nettype wire

@@ verif/tsd_result_checker.sv @@
`timescale 1ns / 1ps
module tsd_result_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       i_busy,
    input  wire tsd_pkg::t_in_item          i_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [tsd_pkg::CNT_W-1:0]  i_cfg_data,
    input  wire logic                       i_strobe,
    input  wire tsd_pkg::t_out_item         i_result,
    output int                              o_errors,
    output int                              o_outstanding
);

    localparam int NREC = tsd_pkg::MAX_CPUS;

    // shadow copy of the tracker
    logic [tsd_pkg::CNT_W-1:0]  cpus_cfg;
    logic                       rec_live  [NREC];
    tsd_pkg::t_rec              rec_range [NREC];
    logic [NREC-1:0]            rec_acks  [NREC];
    logic [tsd_pkg::CNT_W-1:0]  rec_count [NREC];

    tsd_pkg::t_out_item notices_due [$];
    int mismatches = 0;

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
    end

    function automatic int active_cpus();
        int n;
        n = int'(cpus_cfg);
        if (n < 1) n = 1;
        if (n > NREC) n = NREC;
        return n;
    endfunction

    function automatic tsd_pkg::t_out_item notice(tsd_pkg::t_kind kind, logic [4:0] target,
                                                  logic [4:0] init, tsd_pkg::t_rec rng);
        tsd_pkg::t_out_item r;
        r.kind       = kind;
        r.target_cpu = target;
        r.initiator  = init;
        r.inv_asid   = rng.asid;
        r.inv_addr   = rng.addr;
        r.inv_length = rng.length;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic model_request(input tsd_pkg::t_in_item it);
        tsd_pkg::t_out_item burst [$];
        tsd_pkg::t_rec      blank;
        int n;
        int c;
        n     = active_cpus();
        c     = int'(it.cpu_id);
        blank = '0;
        if (c >= n) begin
            burst.push_back(notice(tsd_pkg::KIND_BADCPU, 5'd0, it.cpu_id, blank));
        end else if (it.operation == tsd_pkg::OP_TRIGGER) begin
            if (rec_live[c]) begin
                burst.push_back(notice(tsd_pkg::KIND_BUSY, 5'd0, it.cpu_id, blank));
            end else begin
                rec_range[c].asid   = it.asid & tsd_pkg::ASID_MASK;
                rec_range[c].addr   = it.addr;
                rec_range[c].length = it.length;
                rec_acks[c]         = '0;
                rec_acks[c][c]      = 1'b1;
                rec_count[c]        = tsd_pkg::CNT_W'(1);
                rec_live[c]         = 1'b1;
                burst.push_back(notice(tsd_pkg::KIND_INVAL, it.cpu_id, it.cpu_id,
                                       rec_range[c]));
                if (rec_count[c] >= n) begin
                    rec_live[c] = 1'b0;
                    burst.push_back(notice(tsd_pkg::KIND_DONE, 5'd0, it.cpu_id, rec_range[c]));
                end
            end
        end else begin
            for (int i = 0; i < NREC; i++) begin
                if (rec_live[i]) begin
                    if (!rec_acks[i][c]) begin
                        burst.push_back(notice(tsd_pkg::KIND_INVAL, it.cpu_id, 5'(i),
                                               rec_range[i]));
                        rec_acks[i][c] = 1'b1;
                        rec_count[i]   = rec_count[i] + 1'b1;
                    end
                    // a lowered cpu count can finish a record this cpu already acked
                    if (rec_count[i] >= n) begin
                        rec_live[i] = 1'b0;
                        burst.push_back(notice(tsd_pkg::KIND_DONE, 5'd0, 5'(i), rec_range[i]));
                    end
                end
            end
            if (burst.size() == 0)
                burst.push_back(notice(tsd_pkg::KIND_NONE, 5'd0, it.cpu_id, blank));
        end
        burst[burst.size()-1].last = 1'b1;
        foreach (burst[j]) notices_due.push_back(burst[j]);
    endtask

    always @(posedge i_clk) begin
        tsd_pkg::t_out_item exp;
        if (!i_rst_n) begin
            cpus_cfg = tsd_pkg::CFG_RESET;
            for (int i = 0; i < NREC; i++) begin
                rec_live[i]  = 1'b0;
                rec_range[i] = '0;
                rec_acks[i]  = '0;
                rec_count[i] = '0;
            end
            notices_due.delete();
        end else begin
            if (i_strobe) begin
                if (notices_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind=%0d init=%0d at %0t",
                                 i_result.kind, i_result.initiator, $realtime);
                end else begin
                    exp = notices_due.pop_front();
                    if (i_result !== exp) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  exp kind=%0d tgt=%0d init=%0d asid=%h addr=%h len=%h last=%0d",
                                     exp.kind, exp.target_cpu, exp.initiator, exp.inv_asid,
                                     exp.inv_addr, exp.inv_length, exp.last);
                            $display("  got kind=%0d tgt=%0d init=%0d asid=%h addr=%h len=%h last=%0d",
                                     i_result.kind, i_result.target_cpu, i_result.initiator,
                                     i_result.inv_asid, i_result.inv_addr, i_result.inv_length,
                                     i_result.last);
                        end
                    end
                end
            end
            // a transaction at this edge still sees the count held before the write
            if (i_start && !i_busy)
                model_request(i_item);
            if (i_cfg_we)
                cpus_cfg = i_cfg_data;
        end
        o_errors      = mismatches;
        o_outstanding = notices_due.size();
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

    localparam int LIMIT_CYCLES = 200000;
    localparam int NREC         = tsd_pkg::MAX_CPUS;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       start      = 1'b0;
    tsd_pkg::t_in_item          i_item     = '0;
    logic                       i_cfg_we   = 1'b0;
    logic [tsd_pkg::CNT_W-1:0]  i_cfg_data = '0;
    wire logic                  busy;
    wire logic                  o_strobe;
    tsd_pkg::t_out_item         o_result;

    int errors;
    int outstanding;
    int cycle_count = 0;
    int calm_left   = 0;
    int cur_cpus    = 8;

    tlb_shootdown_tracker_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    tsd_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_strobe      (o_strobe),
        .i_result      (o_result),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // bursts of back-to-back transactions between random gaps
    function automatic int draw_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            calm_left = $urandom_range(6, 20);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic send(input logic op, input logic [4:0] cpu, input logic [15:0] asid,
                        input logic [63:0] addr, input logic [31:0] len);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_item.operation <= op;
        i_item.cpu_id    <= cpu;
        i_item.asid      <= asid;
        i_item.addr      <= addr;
        i_item.length    <= len;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0 || busy) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_cpus(input int value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[tsd_pkg::CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_cpus = value;
        if (cur_cpus < 1) cur_cpus = 1;
        if (cur_cpus > NREC) cur_cpus = NREC;
    endtask

    task automatic random_phase(input int cfg_value, input int count);
        logic        op;
        logic [4:0]  cpu;
        logic [15:0] asid;
        logic [63:0] addr;
        logic [31:0] len;
        set_cpus(cfg_value);
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any cpu id, any operation
                cpu = 5'($urandom_range(0, 31));
                op  = 1'($urandom_range(0, 1));
            end else begin
                cpu = 5'($urandom_range(0, cur_cpus - 1));
                op  = ($urandom_range(0, 9) < 4) ? tsd_pkg::OP_TRIGGER : tsd_pkg::OP_SERVICE;
            end
            case ($urandom_range(0, 7))
                0: begin
                    asid = '1;
                    addr = '1;
                    len  = '1;
                end
                1: begin
                    asid = '0;
                    addr = '0;
                    len  = '0;
                end
                default: begin
                    asid = 16'($urandom);
                    addr = {$urandom, $urandom};
                    len  = $urandom;
                end
            endcase
            send(op, cpu, asid, addr, len);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: nothing pending, extremes of the range fields, busy, bad cpu
        send(tsd_pkg::OP_SERVICE, 5'd0, 16'h0000, 64'h0, 32'h0);
        send(tsd_pkg::OP_TRIGGER, 5'd0, 16'hFFFF, '1, '1);
        send(tsd_pkg::OP_TRIGGER, 5'd0, 16'h1234, 64'h5, 32'h6);
        send(tsd_pkg::OP_TRIGGER, 5'd7, 16'h0000, 64'h0, 32'h0);
        send(tsd_pkg::OP_SERVICE, 5'd8, 16'hFFFF, '1, '1);
        send(tsd_pkg::OP_TRIGGER, 5'd31, 16'hFFFF, '1, '1);
        for (int c = 1; c <= 7; c++)
            send(tsd_pkg::OP_SERVICE, 5'(c), 16'($urandom), {$urandom, $urandom}, $urandom);
        send(tsd_pkg::OP_SERVICE, 5'd7, 16'h0, 64'h0, 32'h0);

        // cpu count lowered below the acks of a record still open
        set_cpus(2);
        send(tsd_pkg::OP_SERVICE, 5'd3, 16'h0, 64'h0, 32'h0);
        send(tsd_pkg::OP_SERVICE, 5'd1, 16'h0, 64'h0, 32'h0);

        // single cpu: self-invalidate and completion together
        set_cpus(1);
        send(tsd_pkg::OP_TRIGGER, 5'd0, 16'hA5A5, 64'hDEAD_BEEF_0000_1000, 32'h1000);
        send(tsd_pkg::OP_TRIGGER, 5'd1, 16'h0, 64'h0, 32'h0);
        send(tsd_pkg::OP_SERVICE, 5'd0, 16'h0, 64'h0, 32'h0);

        // out of range counts clamp at both ends
        set_cpus(0);
        send(tsd_pkg::OP_TRIGGER, 5'd0, 16'h00FF, 64'h1, 32'h1);
        set_cpus(63);
        send(tsd_pkg::OP_TRIGGER, 5'd5, 16'hFF00, 64'h8000_0000_0000_0000, 32'h8000_0000);
        send(tsd_pkg::OP_SERVICE, 5'd7, 16'h0, 64'h0, 32'h0);

        random_phase(8, 25);
        random_phase(1, 12);
        random_phase(63, 25);
        random_phase(3, 20);
        random_phase(0, 10);
        random_phase(5, 20);
        random_phase(32, 20);
        random_phase(2, 18);

        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
